// File: hdl/tsu_pkg.sv
// Shared types, constants and output formatting for trig_series_unit.
// No dependencies; used by every module under hdl/.
package tsu_pkg;

    // Internal format: signed, 40 fraction bits, held in 64 bits.
    localparam int IFRAC = 40;
    localparam int RSHIFT = 62;
    localparam logic [63:0] LIM = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE = 64'h0000_0100_0000_0000;
    localparam logic [48:0] OUT_POS_MAX = 49'h0_7FFF_FFFF_FFFF;
    localparam logic [48:0] OUT_NEG_MAX = 49'h0_8000_0000_0000;

    // Function select codes
    typedef enum logic [1:0] {
        CMD_SIN = 2'd0,
        CMD_COS = 2'd1,
        CMD_TAN = 2'd2,
        CMD_COT = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] angle;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] value;
        logic               div_zero;
    } out_word_t;

    // Request to the shared multiplier
    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic               inv;    // negate the product
        logic               f62;    // shift by 62 instead of 40
    } mul_req_t;

    // Request to the divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic        neg;
    } div_req_t;

    // Saturate a magnitude into the signed 48-bit output format.
    function automatic logic [47:0] to_out(input logic neg, input logic [63:0] m);
        logic [63:0] c;
        logic [63:0] r;
        c = m;
        if (!neg && m > {15'd0, OUT_POS_MAX}) begin
            c = {15'd0, OUT_POS_MAX};
        end
        if (neg && m > {15'd0, OUT_NEG_MAX}) begin
            c = {15'd0, OUT_NEG_MAX};
        end
        r = neg ? (64'd0 - c) : c;
        return r[47:0];
    endfunction

endpackage

// File: hdl/tsu_mul.sv
// Shared multiply unit: 64x64 magnitude product from four 32x32 partial
// products, shift by 40 or 62, clamp to +-LIM. Depends on tsu_pkg.
module tsu_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  tsu_pkg::mul_req_t   req,
    output logic                done,
    output logic signed [63:0]  res
);

    logic         busy_reg, busy_next;
    logic         fin_reg, fin_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic [63:0]  a_reg, a_next;
    logic [63:0]  b_reg, b_next;
    logic         neg_reg, neg_next;
    logic         f62_reg, f62_next;
    logic [127:0] acc_reg, acc_next;
    logic         done_reg, done_next;
    logic signed [63:0] res_reg, res_next;

    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [87:0]  shifted;
    logic [63:0]  mag;

    // Partial product for the current step
    always_comb begin
        a_half = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        pp = 64'(a_half) * 64'(b_half);
        case (cnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // Final scale and clamp
    always_comb begin
        shifted = f62_reg ? {22'd0, acc_reg[127:62]} : acc_reg[127:40];
        mag = (shifted > {24'd0, tsu_pkg::LIM}) ? tsu_pkg::LIM : shifted[63:0];
    end

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        neg_next  = neg_reg;
        f62_next  = f62_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            a_next    = req.a[63] ? (64'd0 - req.a) : req.a;
            b_next    = req.b[63] ? (64'd0 - req.b) : req.b;
            neg_next  = req.a[63] ^ req.b[63] ^ req.inv;
            f62_next  = req.f62;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = acc_reg + pp_sh;
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end else if (fin_reg) begin
            done_next = 1'b1;
            res_next  = neg_reg ? (64'sd0 - signed'(mag)) : signed'(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
        f62_reg <= f62_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: hdl/tsu_div.sv
// Restoring divider: |num| * 2^32 / |den|, one quotient bit per cycle,
// saturated to the 48-bit output format. Depends on tsu_pkg.
module tsu_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  tsu_pkg::div_req_t req,
    output logic              done,
    output logic [47:0]       quo
);

    localparam int STEPS = 95;

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [94:0] sr_reg, sr_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] den_reg, den_next;
    logic [48:0] q_reg, q_next;
    logic        over_reg, over_next;
    logic        neg_reg, neg_next;
    logic        done_reg, done_next;
    logic [47:0] quo_reg, quo_next;

    logic [63:0] rem_sh;
    logic        qb;
    logic [48:0] q_try;

    always_comb begin
        rem_sh = {rem_reg[62:0], sr_reg[94]};
        qb     = (rem_sh >= den_reg);
        q_try  = {q_reg[47:0], qb};
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sr_next   = sr_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        over_next = over_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = 7'(STEPS - 1);
            sr_next   = {req.num[62:0], 32'd0};
            rem_next  = '0;
            den_next  = req.den;
            q_next    = '0;
            over_next = 1'b0;
            neg_next  = req.neg;
        end else if (busy_reg) begin
            sr_next  = {sr_reg[93:0], 1'b0};
            rem_next = qb ? (rem_sh - den_reg) : rem_sh;
            // quotient freezes once past the output range
            if (!over_reg) begin
                q_next = q_try;
                if (q_try > tsu_pkg::OUT_NEG_MAX) begin
                    over_next = 1'b1;
                end
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quo_next  = tsu_pkg::to_out(neg_reg,
                    {15'd0, (over_reg ? q_reg : q_try)});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        sr_reg   <= sr_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        over_reg <= over_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// File: hdl/trig_series_unit.sv
// trig_series_unit top: sequencer for sine/cosine series, tangent, cotangent.
// Depends on tsu_pkg, tsu_mul, tsu_div.
//
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------
//  input    | s_valid / s_ready    | s_data  (cmd, angle)
//  result   | m_valid / m_ready    | m_data  (value, div_zero)
//
// One word at a time; s_ready is high only while the sequencer is idle.
// Each multiply runs as 4 partial-product steps in the shared multiplier;
// a word takes one square, then two multiplies per series term. Sine and
// cosine run one series; tangent/cotangent run the sine series, then the
// cosine series on the same square, and then the divider.
// Reset clears the sequencer and the result valid; a stalled result holds in
// the output register while the sequencer waits at its last step.
module trig_series_unit #(
    parameter int TERMS           = 24,
    parameter int ANGLE_FRAC_BITS = 28
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tsu_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tsu_pkg::out_word_t   m_data
);

    localparam int XSH = tsu_pkg::IFRAC - ANGLE_FRAC_BITS;
    localparam int NK  = 2 * TERMS;
    localparam int KW  = $clog2(NK + 1);
    localparam int KIW = $clog2(NK);
    localparam int CW  = $clog2(TERMS + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQ, ST_TA, ST_TB, ST_DIV, ST_FIN
    } state_t;

    // Reciprocal table: floor(2^62 / (k(k+1))), index k-1
    logic [63:0] recip_tab [NK];
    genvar g;
    generate
        for (g = 0; g < NK; g++) begin : g_rcp
            localparam logic [63:0] RCP = (64'd1 << 62) / (64'(g + 1) * 64'(g + 2));
            assign recip_tab[g] = RCP;
        end
    endgenerate

    state_t             state_reg;
    logic [1:0]         cmd_reg;
    logic               second_reg;
    logic signed [63:0] x_reg, x2_reg, sum_reg, sn_reg;
    logic [KW-1:0]      k_reg;
    logic [CW-1:0]      cnt_reg;
    tsu_pkg::mul_req_t  mreq_reg;
    tsu_pkg::div_req_t  dreq_reg;
    logic               m_valid_reg;
    tsu_pkg::out_word_t m_data_reg;
    tsu_pkg::out_word_t res_reg;

    logic               mul_done;
    logic signed [63:0] mul_res;
    logic               div_done;
    logic [47:0]        div_quo;

    logic signed [63:0] x_in;
    logic signed [63:0] sum_add, sum_sat;
    logic [KW-1:0]      km1;
    logic [63:0]        recip;
    logic [63:0]        sum_mag;
    logic signed [63:0] num_v, den_v;

    tsu_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq_reg),
        .done    (mul_done),
        .res     (mul_res)
    );

    tsu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Datapath helpers
    always_comb begin
        x_in    = 64'(s_data.angle) <<< XSH;
        km1     = k_reg - KW'(1);
        recip   = recip_tab[km1[KIW-1:0]];
        sum_add = sum_reg + mul_res;
        if (sum_add > signed'(tsu_pkg::LIM)) begin
            sum_sat = signed'(tsu_pkg::LIM);
        end else if (sum_add < -signed'(tsu_pkg::LIM)) begin
            sum_sat = -signed'(tsu_pkg::LIM);
        end else begin
            sum_sat = sum_add;
        end
        sum_mag = sum_sat[63] ? (64'd0 - sum_sat) : sum_sat;
        num_v   = (cmd_reg == tsu_pkg::CMD_TAN) ? sn_reg : sum_sat;
        den_v   = (cmd_reg == tsu_pkg::CMD_TAN) ? sum_sat : sn_reg;
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            mreq_reg.start <= 1'b0;
            dreq_reg.start <= 1'b0;
        end else begin
            // output register: loaded from FIN, cleared once taken
            if (state_reg == ST_FIN && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg    <= s_data.cmd;
                        x_reg      <= x_in;
                        second_reg <= 1'b0;
                        mreq_reg   <= '{start: 1'b1, a: x_in, b: x_in, inv: 1'b0, f62: 1'b0};
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    if (mul_done) begin
                        x2_reg  <= mul_res;
                        cnt_reg <= CW'(1);
                        if (cmd_reg == tsu_pkg::CMD_COS) begin
                            sum_reg  <= signed'(tsu_pkg::ONE);
                            k_reg    <= KW'(1);
                            mreq_reg <= '{start: 1'b1, a: signed'(tsu_pkg::ONE), b: mul_res,
                                          inv: 1'b0, f62: 1'b0};
                        end else begin
                            sum_reg  <= x_reg;
                            k_reg    <= KW'(2);
                            mreq_reg <= '{start: 1'b1, a: x_reg, b: mul_res,
                                          inv: 1'b0, f62: 1'b0};
                        end
                        state_reg <= ST_TA;
                    end else begin
                        mreq_reg.start <= 1'b0;
                    end
                end
                ST_TA: begin
                    if (mul_done) begin
                        mreq_reg  <= '{start: 1'b1, a: mul_res, b: signed'(recip),
                                       inv: 1'b1, f62: 1'b1};
                        state_reg <= ST_TB;
                    end else begin
                        mreq_reg.start <= 1'b0;
                    end
                end
                ST_TB: begin
                    if (mul_done) begin
                        sum_reg <= sum_sat;
                        if (cnt_reg != CW'(TERMS)) begin
                            cnt_reg   <= cnt_reg + CW'(1);
                            k_reg     <= k_reg + KW'(2);
                            mreq_reg  <= '{start: 1'b1, a: mul_res, b: x2_reg,
                                           inv: 1'b0, f62: 1'b0};
                            state_reg <= ST_TA;
                        end else if (cmd_reg == tsu_pkg::CMD_SIN
                                  || cmd_reg == tsu_pkg::CMD_COS) begin
                            res_reg.value    <= signed'(tsu_pkg::to_out(sum_sat[63],
                                                        sum_mag >> 8));
                            res_reg.div_zero <= 1'b0;
                            state_reg        <= ST_FIN;
                        end else if (!second_reg) begin
                            // sine done, now the cosine series
                            sn_reg     <= sum_sat;
                            second_reg <= 1'b1;
                            sum_reg    <= signed'(tsu_pkg::ONE);
                            cnt_reg    <= CW'(1);
                            k_reg      <= KW'(1);
                            mreq_reg   <= '{start: 1'b1, a: signed'(tsu_pkg::ONE), b: x2_reg,
                                            inv: 1'b0, f62: 1'b0};
                            state_reg  <= ST_TA;
                        end else if (den_v == 64'sd0) begin
                            res_reg.value    <= '0;
                            res_reg.div_zero <= 1'b1;
                            state_reg        <= ST_FIN;
                        end else begin
                            dreq_reg.start <= 1'b1;
                            dreq_reg.num   <= num_v[63] ? (64'd0 - num_v) : num_v;
                            dreq_reg.den   <= den_v[63] ? (64'd0 - den_v) : den_v;
                            dreq_reg.neg   <= num_v[63] ^ den_v[63];
                            state_reg      <= ST_DIV;
                        end
                    end else begin
                        mreq_reg.start <= 1'b0;
                    end
                end
                ST_DIV: begin
                    // divide start is a one-cycle pulse
                    dreq_reg.start <= 1'b0;
                    if (div_done) begin
                        res_reg.value    <= signed'(div_quo);
                        res_reg.div_zero <= 1'b0;
                        state_reg        <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg <= res_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A zero-divisor result always carries a zero value
    a_dz_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.div_zero |-> m_data.value == 48'sd0)
        else $error("div_zero result with nonzero value");

    // The multiplier and divider only finish while a word is in progress
    a_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !mul_done && !div_done)
        else $error("arithmetic unit finished while idle");

    // Sine and cosine never raise the divide flag
    a_sc_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && (cmd_reg == tsu_pkg::CMD_SIN || cmd_reg == tsu_pkg::CMD_COS)
        |-> !res_reg.div_zero)
        else $error("div_zero set on sine or cosine");

endmodule
